// ===== rtl/lzot_pkg.sv =====
package lzot_pkg;

  // Field widths of the request and result channels.
  localparam int LAYER_ID_W = 4;
  localparam int LEVEL_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int RANGE_W    = 4;

  // Default number of layer slots.
  localparam int DEF_MAX_LAYERS = 16;

  // The level that stands for a hidden layer or an empty stack.
  localparam logic signed [LEVEL_W-1:0] LVL_NONE = '1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_LAYER = 2'd2;

endpackage

// ===== rtl/lzot_req_if.sv =====
interface lzot_req_if
  import lzot_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [LAYER_ID_W-1:0]      layer_id;
  logic signed [LEVEL_W-1:0]  requested_level;

  modport source (output valid, output layer_id, output requested_level, input ready);
  modport sink (input valid, input layer_id, input requested_level, output ready);
endinterface

// ===== rtl/lzot_rsp_if.sv =====
interface lzot_rsp_if
  import lzot_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [LEVEL_W-1:0]  new_level;
  logic signed [LEVEL_W-1:0]  top_now;
  logic                       redraw_needed;
  logic [RANGE_W-1:0]         map_from_level;
  logic [RANGE_W-1:0]         draw_low_level;
  logic signed [LEVEL_W-1:0]  draw_high_level;

  modport source (output valid, output status, output new_level, output top_now,
                  output redraw_needed, output map_from_level, output draw_low_level,
                  output draw_high_level, input ready);
  modport sink (input valid, input status, input new_level, input top_now,
                input redraw_needed, input map_from_level, input draw_low_level,
                input draw_high_level, output ready);
endinterface

// ===== rtl/layer_z_order_table.sv =====
// A request that changes the stack passes S_OLD, a sweep over all SLOTS slots and S_DONE
// before its result is loaded; an ignored request skips the sweep, a slot out of range goes to S_DONE.
// Throughput: one request at a time; the next request is accepted the cycle after the result
// is loaded into the output register, and S_DONE holds until the output register is free.
// The sweep is one read-modify-write pass over the level memory, one slot a cycle.
// Reset (rst_n low, synchronous) hides every layer and empties the stack.
module layer_z_order_table
  import lzot_pkg::*;
#(
  parameter int MAX_LAYERS = DEF_MAX_LAYERS
) (
  input  logic        clk,
  input  logic        rst_n,
  lzot_req_if.sink    in_req,
  lzot_rsp_if.source  out_rsp
);

  // Only slots that a layer id can address ever hold a level; the rest stay hidden for good
  // and never match or shift, so the memory holds at most 2**LAYER_ID_W slots.
  localparam int ID_SPAN = 1 << LAYER_ID_W;
  localparam int SLOTS   = (MAX_LAYERS < ID_SPAN) ? MAX_LAYERS : ID_SPAN;
  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_OLD   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Kind of change that the sweep applies to every slot.
  typedef enum logic [1:0] {
    OP_MOVE,
    OP_HIDE,
    OP_INSERT
  } op_t;

  typedef logic signed [LEVEL_W-1:0] level_t;

  state_t state_r, state_nxt;

  // Level memory: one entry per slot, one write and one registered read per cycle.
  // An entry whose valid bit is clear reads as hidden, which stands in for the reset value.
  level_t           lvl_mem [SLOTS];
  logic [SLOTS-1:0] lvl_vld_r;
  logic [IW-1:0]    rd_addr;
  level_t           rd_data_r;
  logic             rd_vld_r;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  level_t           wr_data;
  level_t           lvl_rd;

  // Request held while it is worked on.
  logic [LAYER_ID_W-1:0] id_r;
  level_t                z_r;

  // Decision made once the named slot's level is known.
  op_t    op_r, op_nxt;
  level_t old_r;
  level_t zc_r, zc_nxt;
  level_t top_r, top_nxt;

  // Sweep control: reads issued so far, and the slot whose data returns this cycle.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pipe_vld_r, pipe_vld_nxt;
  logic [IW-1:0] pipe_idx_r;
  logic          rd_issue;

  // Pending result, and the output register that the consumer sees.
  logic [STATUS_W-1:0] res_status_r;
  level_t              res_newlv_r;
  logic                res_redraw_r;
  logic [RANGE_W-1:0]  res_map_r;
  logic [RANGE_W-1:0]  res_dlo_r;
  level_t              res_dhi_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  level_t              out_newlv_r;
  level_t              out_top_r;
  logic                out_redraw_r;
  logic [RANGE_W-1:0]  out_map_r;
  logic [RANGE_W-1:0]  out_dlo_r;
  level_t              out_dhi_r;

  logic   in_fire;
  logic   id_ok;
  logic   out_free;
  logic   dec_ignore;
  logic   dec_redraw;
  level_t dec_newlv;
  logic [RANGE_W-1:0] dec_map;
  logic [RANGE_W-1:0] dec_dlo;
  level_t dec_dhi;
  level_t z_sum_up;
  level_t top_up;
  level_t top_dn;
  level_t old_dn;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign id_ok        = 32'(in_req.layer_id) < SLOTS;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.new_level       = out_newlv_r;
  assign out_rsp.top_now         = out_top_r;
  assign out_rsp.redraw_needed   = out_redraw_r;
  assign out_rsp.map_from_level  = out_map_r;
  assign out_rsp.draw_low_level  = out_dlo_r;
  assign out_rsp.draw_high_level = out_dhi_r;

  // ---------------------------------------------------------------------------------------
  // Level memory. In the idle state the named slot is read; during the sweep slot cnt_r is
  // read while the previously read slot is written back. The two addresses always
  // differ, so no forwarding path is needed.
  // ---------------------------------------------------------------------------------------
  assign rd_addr = (state_r == S_IDLE) ? in_req.layer_id[IW-1:0] : cnt_r[IW-1:0];
  assign lvl_rd  = rd_vld_r ? rd_data_r : LVL_NONE;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lvl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= lvl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        lvl_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= lvl_vld_r[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Decision, made in S_OLD from the named slot's current level. Because levels are always
  // dense from 0 to the top, any clamped target at or below the top is held by some layer,
  // so the "no layer at target" outcome never arises and needs no search.
  // ---------------------------------------------------------------------------------------
  assign top_up   = top_r + level_t'(1);
  assign top_dn   = top_r - level_t'(1);
  assign old_dn   = lvl_rd - level_t'(1);

  always_comb begin
    op_nxt     = op_r;
    zc_nxt     = zc_r;
    top_nxt    = top_r;
    dec_ignore = 1'b0;
    dec_newlv  = lvl_rd;
    z_sum_up   = '0;
    if (!lvl_rd[LEVEL_W-1]) begin
      if (!z_r[LEVEL_W-1]) begin
        // Shown layer moves; the target is clamped to the top.
        op_nxt    = OP_MOVE;
        zc_nxt    = (z_r > top_r) ? top_r : z_r;
        dec_newlv = zc_nxt;
        // Asking for its own level below the top changes nothing.
        dec_ignore = (zc_nxt == lvl_rd) && (zc_nxt != top_r);
      end else begin
        // Shown layer is hidden and the levels above close up.
        op_nxt    = OP_HIDE;
        zc_nxt    = LVL_NONE;
        top_nxt   = top_dn;
        dec_newlv = LVL_NONE;
      end
    end else if (!z_r[LEVEL_W-1]) begin
      // Hidden layer is inserted; past the top it lands just above it.
      op_nxt    = OP_INSERT;
      zc_nxt    = (z_r > top_r) ? top_up : z_r;
      top_nxt   = top_up;
      dec_newlv = zc_nxt;
    end else begin
      // Hiding a hidden layer changes nothing.
      dec_ignore = 1'b1;
      dec_newlv  = LVL_NONE;
    end
    z_sum_up = zc_nxt + level_t'(1);

    // Redraw ranges. A move down redraws from just above the new level up to the old one;
    // a hide redraws everything below the old level; all other changes touch one level.
    dec_redraw = !dec_ignore;
    dec_map    = '0;
    dec_dlo    = '0;
    dec_dhi    = '0;
    if (!dec_ignore) begin
      if (op_nxt == OP_HIDE) begin
        dec_dhi = old_dn;
      end else if ((op_nxt == OP_MOVE) && (zc_nxt < lvl_rd)) begin
        dec_map = z_sum_up[RANGE_W-1:0];
        dec_dlo = z_sum_up[RANGE_W-1:0];
        dec_dhi = lvl_rd;
      end else begin
        dec_map = zc_nxt[RANGE_W-1:0];
        dec_dlo = zc_nxt[RANGE_W-1:0];
        dec_dhi = zc_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sweep: every slot is read, adjusted for the change and written back.
  // ---------------------------------------------------------------------------------------
  assign rd_issue = (state_r == S_SWEEP) && (cnt_r < CW'(SLOTS));
  assign mem_we   = (state_r == S_SWEEP) && pipe_vld_r;
  assign wr_addr  = pipe_idx_r;

  always_comb begin
    wr_data = lvl_rd;
    if (pipe_idx_r == id_r[IW-1:0]) begin
      wr_data = zc_r;
    end else begin
      unique case (op_r)
        OP_MOVE: begin
          if (zc_r >= old_r) begin
            if ((lvl_rd > old_r) && (lvl_rd <= zc_r)) begin
              wr_data = lvl_rd - level_t'(1);
            end
          end else if ((lvl_rd >= zc_r) && (lvl_rd < old_r)) begin
            wr_data = lvl_rd + level_t'(1);
          end
        end
        OP_HIDE: begin
          if (lvl_rd > old_r) begin
            wr_data = lvl_rd - level_t'(1);
          end
        end
        OP_INSERT: begin
          if (lvl_rd >= zc_r) begin
            wr_data = lvl_rd + level_t'(1);
          end
        end
        default: begin
          wr_data = lvl_rd;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pipe_vld_nxt  = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = id_ok ? S_OLD : S_DONE;
        end
      end
      S_OLD: begin
        cnt_nxt   = '0;
        state_nxt = dec_ignore ? S_DONE : S_SWEEP;
      end
      S_SWEEP: begin
        pipe_vld_nxt = rd_issue;
        if (rd_issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (!rd_issue && pipe_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= LVL_NONE;
      cnt_r       <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_MOVE;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_OLD) begin
        op_r  <= op_nxt;
        top_r <= top_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r         <= in_req.layer_id;
      z_r          <= in_req.requested_level;
      // A slot out of range is answered at once and left untouched.
      res_status_r <= ST_IGNORED;
      res_newlv_r  <= LVL_NONE;
      res_redraw_r <= 1'b0;
      res_map_r    <= '0;
      res_dlo_r    <= '0;
      res_dhi_r    <= '0;
    end
    if (rd_issue) begin
      pipe_idx_r <= cnt_r[IW-1:0];
    end
    if (state_r == S_OLD) begin
      old_r        <= lvl_rd;
      zc_r         <= zc_nxt;
      res_status_r <= dec_ignore ? ST_IGNORED : ST_DONE;
      res_newlv_r  <= dec_newlv;
      res_redraw_r <= dec_redraw;
      res_map_r    <= dec_map;
      res_dlo_r    <= dec_dlo;
      res_dhi_r    <= dec_dhi;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_newlv_r  <= res_newlv_r;
      out_top_r    <= top_r;
      out_redraw_r <= res_redraw_r;
      out_map_r    <= res_map_r;
      out_dlo_r    <= res_dlo_r;
      out_dhi_r    <= res_dhi_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_top_floor: assert property (@(posedge clk) disable iff (!rst_n)
    top_r >= LVL_NONE)
    else $error("top level fell below the empty-stack value");

  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) && (state_nxt == S_DONE) |-> (cnt_r == CW'(SLOTS)))
    else $error("sweep ended before every slot was written back");

  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(rd_issue))
    else $error("write-back without a matching read");

  a_done_redraws: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_DONE) |-> out_redraw_r)
    else $error("completed request reported without a redraw range");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_redraw_r |->
      (out_map_r == '0) && (out_dlo_r == '0) && (out_dhi_r == '0))
    else $error("unused range fields not cleared");

endmodule
